// ===== rtl/nsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, register map and defaults for the Newton square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

    // default data path shape: unsigned Q16.16
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS  = 16;

    // fixed field widths
    localparam int RADICAND_WIDTH = 32;
    localparam int ROOT_WIDTH     = 32;
    localparam int TOL_WIDTH      = 32;
    localparam int ITER_WIDTH     = 6;

    // configuration port
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_ADDR_WIDTH = 3;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_TOLERANCE = 1'b0,
        REG_MAX_ITER  = 1'b1
    } reg_index_t;

    // register reset values
    localparam logic [TOL_WIDTH-1:0]  TOL_RESET      = 32'd1;
    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 6'd40;

endpackage

// ===== rtl/nsr_serial_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_serial_mult
// Shift-add squarer: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module nsr_serial_mult #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [DATA_WIDTH-1:0]     operand,
    output logic                      done,
    output logic [2*DATA_WIDTH-1:0]   product
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0]   mcand_reg;
    logic [2*DATA_WIDTH-1:0] prod_reg;
    logic [2*DATA_WIDTH-1:0] prod_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [DATA_WIDTH:0]     sum;

    // add the multiplicand into the upper half when the low bit is set
    always_comb begin
        sum = {1'b0, prod_reg[2*DATA_WIDTH-1:DATA_WIDTH]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : {(DATA_WIDTH+1){1'b0}});
        prod_next = {sum, prod_reg[DATA_WIDTH-1:1]};
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(DATA_WIDTH);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // product shift register, multiplier held in the low half
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= operand;
            prod_reg  <= {{DATA_WIDTH{1'b0}}, operand};
        end else if (cnt_reg != '0) begin
            prod_reg <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ===== rtl/nsr_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_serial_div
// Restoring divider for (numer << FRAC_BITS) / divisor, one quotient bit per
// cycle, saturating to all ones on overflow or a zero divisor.
// ----------------------------------------------------------------------------
module nsr_serial_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] numer,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient
);

    localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]      num_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] q_reg;
    logic                  over_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   rem_diff;
    logic                  q_bit;
    logic [DATA_WIDTH-1:0] rem_next;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        rem_next  = q_bit ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // numerator, remainder and quotient shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= NUM_W'(numer) << FRAC_BITS;
            div_reg  <= divisor;
            rem_reg  <= '0;
            q_reg    <= '0;
            over_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            num_reg  <= num_reg << 1;
            rem_reg  <= rem_next;
            q_reg    <= {q_reg[DATA_WIDTH-2:0], q_bit};
            over_reg <= over_reg | q_reg[DATA_WIDTH-1];
        end
    end

    assign done     = done_reg;
    assign quotient = over_reg ? {DATA_WIDTH{1'b1}} : q_reg;

endmodule

// ===== rtl/newton_square_root_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_square_root_core
// Unsigned fixed-point square root by Newton-Raphson iteration.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one radicand per item (valid/ready); m_* channel returns
//   root, limit_reached and iterations_used as one item.
//   Registers on the APB-style port: tolerance at 0x0, max_iterations at 0x4.
//   Write them only while the core is idle.
// Sequence: the guess starts at 1.0; each convergence check squares the guess
//   in the serial multiplier, followed by the error compare; each Newton update
//   adds the serial divider. With N updates an item takes N + 1 checks and
//   N divides. The default shape is unsigned Q16.16.
// Throughput: one item at a time; the next radicand is taken as soon as the
//   core is back in idle, even while the previous result waits in the output
//   register.
// Reset: aresetn (synchronous, active low) restores the register defaults and
//   empties the output register.
// Stall: a result held by m_ready low stays stable; the core finishes the
//   next item and then waits for the output register to free up.
// ----------------------------------------------------------------------------
module newton_square_root_core
    import nsr_pkg::*;
#(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
    parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [RADICAND_WIDTH-1:0] s_radicand,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ROOT_WIDTH-1:0]     m_root,
    output logic                      m_limit_reached,
    output logic [ITER_WIDTH-1:0]     m_iterations_used,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_WIDTH-1:0] paddr,
    input  logic [CFG_DATA_WIDTH-1:0] pwdata,
    output logic [CFG_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    // compare width covers the square, the shifted radicand and tolerance
    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int XS_W  = DATA_WIDTH + FRAC_BITS;
    localparam int TS_W  = TOL_WIDTH + FRAC_BITS;
    localparam int CMP_W0 = (SQ_W > XS_W) ? SQ_W : XS_W;
    localparam int CMP_W  = (CMP_W0 > TS_W) ? CMP_W0 : TS_W;

    // starting guess 1.0, saturated when it does not fit
    localparam logic [DATA_WIDTH-1:0] ONE_GUESS = (FRAC_BITS >= DATA_WIDTH)
        ? {DATA_WIDTH{1'b1}}
        : ({{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ERR,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [TOL_WIDTH-1:0]    tol_reg;
    logic [ITER_WIDTH-1:0]   max_iter_reg;
    logic [DATA_WIDTH-1:0]   x_reg;
    logic [DATA_WIDTH-1:0]   g_reg;
    logic [ITER_WIDTH-1:0]   used_reg;
    logic                    flag_reg;
    logic [CMP_W-1:0]        err_reg;
    logic                    mul_start_reg;
    logic                    div_start_reg;
    logic                    m_valid_reg;
    logic [ROOT_WIDTH-1:0]   m_root_reg;
    logic                    m_flag_reg;
    logic [ITER_WIDTH-1:0]   m_used_reg;

    logic                    mul_done;
    logic [SQ_W-1:0]         product;
    logic                    div_done;
    logic [DATA_WIDTH-1:0]   quotient;
    logic [CMP_W-1:0]        sq_ext;
    logic [CMP_W-1:0]        target;
    logic [CMP_W-1:0]        tol_shift;
    logic [DATA_WIDTH-1:0]   g_update;
    logic                    cfg_write;
    reg_index_t              cfg_index;

    // guess squarer
    nsr_serial_mult #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .operand (g_reg),
        .done    (mul_done),
        .product (product)
    );

    // x / guess divider
    nsr_serial_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .numer    (x_reg),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // error operands aligned to the square's scale
    always_comb begin
        sq_ext    = CMP_W'(product);
        target    = CMP_W'(x_reg) << FRAC_BITS;
        tol_shift = CMP_W'(tol_reg) << FRAC_BITS;
        g_update  = (quotient >> 1) + (g_reg >> 1)
                  + DATA_WIDTH'(quotient[0] & g_reg[0]);
    end

    // configuration registers
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[2]);
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg      <= TOL_RESET;
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TOLERANCE: tol_reg      <= pwdata[TOL_WIDTH-1:0];
                REG_MAX_ITER:  max_iter_reg <= pwdata[ITER_WIDTH-1:0];
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (cfg_index)
            REG_TOLERANCE: prdata = CFG_DATA_WIDTH'(tol_reg);
            REG_MAX_ITER:  prdata = CFG_DATA_WIDTH'(max_iter_reg);
        endcase
    end

    // iteration sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            // output register drains unless a new item loads in the same cycle
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg         <= DATA_WIDTH'(s_radicand);
                        g_reg         <= ONE_GUESS;
                        used_reg      <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= (sq_ext >= target) ? (sq_ext - target)
                                                    : (target - sq_ext);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    priority if (err_reg < tol_shift) begin
                        flag_reg  <= 1'b0;
                        state_reg <= ST_DONE;
                    end else if (used_reg >= max_iter_reg) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        g_reg         <= g_update;
                        used_reg      <= used_reg + ITER_WIDTH'(1);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_root_reg  <= ROOT_WIDTH'(g_reg);
                        m_flag_reg  <= flag_reg;
                        m_used_reg  <= used_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_root            = m_root_reg;
    assign m_limit_reached   = m_flag_reg;
    assign m_iterations_used = m_used_reg;

endmodule

// ===== rtl/nsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for the Newton square root core, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_checker
    import nsr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ROOT_WIDTH-1:0] m_root,
    input logic                  m_limit_reached,
    input logic [ITER_WIDTH-1:0] m_iterations_used
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item present after reset");

    // one item at a time: input closes right after an item is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after an item was taken");

    // a fresh result never shows up the cycle after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result item appeared one cycle after accept");

    // stalled result holds its fields
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root)
            && $stable(m_limit_reached) && $stable(m_iterations_used))
        else $error("result item changed while stalled");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_root            (m_root),
    .m_limit_reached   (m_limit_reached),
    .m_iterations_used (m_iterations_used)
);
